@@ rtl/core/bgv_pkg.sv @@
// Shared types and constants for the bandgap VDD estimator.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
`default_nettype none

package bgv_pkg;

    // Serial divider geometry: 24-bit dividend (bandgap << 12), 12-bit divisor.
    localparam int DIV_W  = 24;
    localparam int DEN_W  = 12;
    localparam int NBITS_W = 5;

    localparam int MV_W   = 12;
    localparam int SMP_W  = 12;
    localparam int VDD_W  = 16;
    localparam int CFG_W  = 8;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_HI_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_LO_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_HI_B = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM_LO_B = 2'd3;

    // Trim layout marks (upper nibble of the second trim byte).
    localparam logic [3:0] MARK_A     = 4'h0;
    localparam logic [3:0] MARK_A_OFS = 4'h8;
    localparam logic [3:0] MARK_B     = 4'h9;

    localparam logic [MV_W-1:0]  MARK_A_OFS_MV = 12'd33;
    localparam logic [VDD_W-1:0] VDD_SAT       = 16'hFFFF;

    // Opcodes.
    localparam logic OP_SERIES = 1'b0;
    localparam logic OP_DIRECT = 1'b1;

    typedef struct packed {
        logic [MV_W-1:0] mv;
        logic            valid;
        logic            under;
    } t_trim_info;

    typedef struct packed {
        logic               start;
        logic [NBITS_W-1:0] nbits;
    } t_div_cmd;

endpackage

`default_nettype wire

@@ rtl/core/bgv_trim.sv @@
// Trim register bank and bandgap millivolt decode.
// Depends on bgv_pkg for register indexes, mark codes and t_trim_info.
`default_nettype none

module bgv_trim (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [bgv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bgv_pkg::CFG_W-1:0]      i_cfg_data,
    output bgv_pkg::t_trim_info                 o_info
);

    logic [bgv_pkg::CFG_W-1:0] r_hi_a, r_lo_a, r_hi_b, r_lo_b;
    logic [bgv_pkg::MV_W-1:0]  raw;
    logic [bgv_pkg::MV_W+1:0]  x3;
    logic [bgv_pkg::MV_W-1:0]  mv0;
    logic [3:0]                mark;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi_a <= '0;
            r_lo_a <= '0;
            r_hi_b <= '0;
            r_lo_b <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bgv_pkg::CFG_TRIM_HI_A: r_hi_a <= i_cfg_data;
                bgv_pkg::CFG_TRIM_LO_A: r_lo_a <= i_cfg_data;
                bgv_pkg::CFG_TRIM_HI_B: r_hi_b <= i_cfg_data;
                bgv_pkg::CFG_TRIM_LO_B: r_lo_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign mark = r_lo_a[7:4];
    assign raw  = (mark == bgv_pkg::MARK_B) ? {r_hi_b, r_lo_b[3:0]} : {r_hi_a, r_lo_a[3:0]};
    // Three quarters of the raw code: raw + 2*raw, then drop two bits.
    assign x3   = {2'b00, raw} + {1'b0, raw, 1'b0};
    assign mv0  = x3[bgv_pkg::MV_W+1:2];

    always_comb begin
        o_info.mv    = mv0;
        o_info.valid = 1'b1;
        o_info.under = 1'b0;
        case (mark)
            bgv_pkg::MARK_A: ;
            bgv_pkg::MARK_B: ;
            bgv_pkg::MARK_A_OFS: begin
                if (mv0 < bgv_pkg::MARK_A_OFS_MV) begin
                    o_info.mv    = '0;
                    o_info.under = 1'b1;
                end else begin
                    o_info.mv = mv0 - bgv_pkg::MARK_A_OFS_MV;
                end
            end
            default: begin
                o_info.mv    = '0;
                o_info.valid = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/bgv_divider.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on bgv_pkg for widths and the t_div_cmd command struct.
`default_nettype none

module bgv_divider (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire bgv_pkg::t_div_cmd           i_cmd,
    input  wire logic [bgv_pkg::DIV_W-1:0]   i_num,
    input  wire logic [bgv_pkg::DEN_W-1:0]   i_den,
    output logic                             o_done,
    output logic [bgv_pkg::DIV_W-1:0]        o_quo
);

    logic [bgv_pkg::DIV_W-1:0]   r_rq;
    logic [bgv_pkg::DEN_W-1:0]   r_rem;
    logic [bgv_pkg::DEN_W-1:0]   r_den;
    logic [bgv_pkg::NBITS_W-1:0] r_cnt;
    logic                        r_run;
    logic                        r_done;
    logic [bgv_pkg::DEN_W:0]     rem_sh;
    logic [bgv_pkg::DEN_W+1:0]   diff;
    logic                        qbit;

    // The dividend is left-aligned in r_rq; its bits leave at the top while
    // quotient bits enter at the bottom.
    assign rem_sh = {r_rem, r_rq[bgv_pkg::DIV_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_den};
    assign qbit   = !diff[bgv_pkg::DEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_run <= 1'b1;
                r_cnt <= i_cmd.nbits;
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == bgv_pkg::NBITS_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rq  <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_run) begin
            r_rq  <= {r_rq[bgv_pkg::DIV_W-2:0], qbit};
            r_rem <= qbit ? diff[bgv_pkg::DEN_W-1:0] : rem_sh[bgv_pkg::DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_rq;

endmodule

`default_nettype wire

@@ rtl/core/bandgap_vdd_estimator_top.sv @@
// A direct conversion strobes its result after one bit-serial division (VDD), the last
// series sample after two in turn (the average, then VDD, both bit-serial).
// A zero direct sample strobes the cycle after start, a zero average once its division ends.
// Other series samples are only summed and are taken whenever the block is idle; otherwise one item at a time through
// the shared divider, busy high until the strobe, which may overlap the next beat.
// Reset (synchronous, active low) clears the trim registers, the state, the strobe, the series count and sum.
`default_nettype none

module bandgap_vdd_estimator_top #(
    parameter int SAMPLES_PER_MEASURE = 5,
    parameter int SAMPLES_DISCARDED   = 2
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    output logic                                o_busy,
    input  wire logic                           i_opcode,
    input  wire logic [bgv_pkg::SMP_W-1:0]      i_sample,
    input  wire logic                           i_cfg_we,
    input  wire logic [bgv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bgv_pkg::CFG_W-1:0]      i_cfg_data,
    output logic                                o_strobe,
    output logic [bgv_pkg::VDD_W-1:0]           o_vdd_mv,
    output logic                                o_error,
    output logic                                o_trim_valid
);

    localparam int KEPT  = (SAMPLES_PER_MEASURE > SAMPLES_DISCARDED) ?
                           SAMPLES_PER_MEASURE - SAMPLES_DISCARDED : 0;
    localparam int SUM_W = $clog2(SAMPLES_PER_MEASURE) + bgv_pkg::SMP_W;
    localparam int CNT_W = $clog2(SAMPLES_PER_MEASURE);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_AVG  = 3'b010,
        S_VDD  = 3'b100
    } t_state;

    t_state                       r_state, n_state;
    logic [CNT_W-1:0]             r_count, n_count;
    logic [SUM_W-1:0]             r_sum, n_sum;
    logic                         r_strobe, n_strobe;
    logic [bgv_pkg::VDD_W-1:0]    r_vdd, n_vdd;
    logic                         r_err, n_err;
    logic                         r_tv, n_tv;

    bgv_pkg::t_trim_info          trim;
    bgv_pkg::t_div_cmd            cmd;
    logic [bgv_pkg::DIV_W-1:0]    div_num;
    logic [bgv_pkg::DEN_W-1:0]    div_den;
    logic                         div_done;
    logic [bgv_pkg::DIV_W-1:0]    div_quo;
    logic [SUM_W-1:0]             sum_add;
    logic [bgv_pkg::DEN_W-1:0]    avg;
    logic                         over;

    bgv_trim u_trim (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_info      (trim)
    );

    bgv_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign sum_add = (int'(r_count) >= SAMPLES_DISCARDED) ?
                     r_sum + SUM_W'(i_sample) : r_sum;
    assign avg     = div_quo[bgv_pkg::DEN_W-1:0];
    assign over    = |div_quo[bgv_pkg::DIV_W-1:bgv_pkg::VDD_W];

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_sum     = r_sum;
        n_strobe  = 1'b0;
        n_vdd     = r_vdd;
        n_err     = r_err;
        n_tv      = r_tv;
        cmd.start = 1'b0;
        cmd.nbits = bgv_pkg::NBITS_W'(bgv_pkg::DIV_W);
        div_num   = {trim.mv, {(bgv_pkg::DIV_W - bgv_pkg::MV_W){1'b0}}};
        div_den   = i_sample;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_opcode == bgv_pkg::OP_DIRECT) begin
                        if (i_sample == '0) begin
                            n_strobe = 1'b1;
                            n_vdd    = bgv_pkg::VDD_SAT;
                            n_err    = 1'b1;
                            n_tv     = trim.valid;
                        end else begin
                            cmd.start = 1'b1;
                            n_state   = S_VDD;
                        end
                    end else if (r_count == CNT_W'(SAMPLES_PER_MEASURE - 1)) begin
                        n_count = '0;
                        n_sum   = '0;
                        if (KEPT == 0) begin
                            n_strobe = 1'b1;
                            n_vdd    = bgv_pkg::VDD_SAT;
                            n_err    = 1'b1;
                            n_tv     = trim.valid;
                        end else begin
                            // Average first: the sum is left-aligned so only its
                            // own width of quotient bits is produced.
                            cmd.start = 1'b1;
                            cmd.nbits = bgv_pkg::NBITS_W'(SUM_W);
                            div_num   = {sum_add, {(bgv_pkg::DIV_W - SUM_W){1'b0}}};
                            div_den   = bgv_pkg::DEN_W'(KEPT);
                            n_state   = S_AVG;
                        end
                    end else begin
                        n_count = r_count + 1'b1;
                        n_sum   = sum_add;
                    end
                end
            end
            S_AVG: begin
                if (div_done) begin
                    if (avg == '0) begin
                        n_strobe = 1'b1;
                        n_vdd    = bgv_pkg::VDD_SAT;
                        n_err    = 1'b1;
                        n_tv     = trim.valid;
                        n_state  = S_IDLE;
                    end else begin
                        cmd.start = 1'b1;
                        div_den   = avg;
                        n_state   = S_VDD;
                    end
                end
            end
            S_VDD: begin
                if (div_done) begin
                    n_strobe = 1'b1;
                    n_vdd    = over ? bgv_pkg::VDD_SAT : div_quo[bgv_pkg::VDD_W-1:0];
                    n_err    = over | trim.under;
                    n_tv     = trim.valid;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_sum    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_sum    <= n_sum;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vdd <= n_vdd;
        r_err <= n_err;
        r_tv  <= n_tv;
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_vdd_mv     = r_vdd;
    assign o_error      = r_err;
    assign o_trim_valid = r_tv;

endmodule

`default_nettype wire

@@ rtl/core/bgv_checker.sv @@
// Port-level checks for the bandgap VDD estimator, bound to the top level.
// Depends on bgv_pkg for widths and the saturation constant.
`default_nettype none

module bgv_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_start,
    input wire logic                         o_busy,
    input wire logic                         i_opcode,
    input wire logic [bgv_pkg::SMP_W-1:0]    i_sample,
    input wire logic                         o_strobe,
    input wire logic [bgv_pkg::VDD_W-1:0]    o_vdd_mv,
    input wire logic                         o_error,
    input wire logic                         o_trim_valid
);

    // A direct beat with a zero sample saturates on the next cycle.
    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_opcode && (i_sample == '0))
        |=> (o_strobe && o_error && (o_vdd_mv == bgv_pkg::VDD_SAT)))
        else $error("zero divisor not saturated");

    // A direct beat with a non-zero sample occupies the divider.
    a_direct_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_opcode && (i_sample != '0)) |=> (o_busy && !o_strobe))
        else $error("direct conversion did not start");

    // The block only goes idle by delivering a result.
    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_busy) && $past(i_rst_n)) |-> o_strobe)
        else $error("busy dropped without a result");

    // An unknown trim layout can only give zero or a saturated value.
    a_bad_trim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_trim_valid)
        |-> ((o_vdd_mv == '0) || (o_vdd_mv == bgv_pkg::VDD_SAT)))
        else $error("unknown trim gave a non-zero estimate");

endmodule

bind bandgap_vdd_estimator_top bgv_checker u_bgv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (i_start),
    .o_busy       (o_busy),
    .i_opcode     (i_opcode),
    .i_sample     (i_sample),
    .o_strobe     (o_strobe),
    .o_vdd_mv     (o_vdd_mv),
    .o_error      (o_error),
    .o_trim_valid (o_trim_valid)
);

`default_nettype wire

@@ bench/bgv_vdd_checker.sv @@
// Checker for the bandgap VDD estimator: follows trim writes and accepted beats, predicts
// each result and compares it with the next strobed result. Depends on bgv_pkg.
`default_nettype none

module bgv_vdd_checker #(
    parameter int SAMPLES_PER_MEASURE = 5,
    parameter int SAMPLES_DISCARDED   = 2
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic                           i_busy,
    input  wire logic                           i_opcode,
    input  wire logic [bgv_pkg::SMP_W-1:0]      i_sample,
    input  wire logic                           i_cfg_we,
    input  wire logic [bgv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bgv_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                           i_strobe,
    input  wire logic [bgv_pkg::VDD_W-1:0]      i_vdd_mv,
    input  wire logic                           i_error,
    input  wire logic                           i_trim_valid,
    output int                                  o_pending,
    output int                                  o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import bgv_pkg::*;

    typedef struct packed {
        logic [VDD_W-1:0] vdd_mv;
        logic             error;
        logic             trim_valid;
    } t_vdd_estimate;

    logic [CFG_W-1:0] trim_hi_a, trim_lo_a, trim_hi_b, trim_lo_b;
    int unsigned      series_count;
    int unsigned      series_sum;
    t_vdd_estimate    expected_vdd_q[$];
    int               mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    function automatic t_vdd_estimate predict_vdd(input int unsigned divisor);
        logic [3:0]    mark;
        int unsigned   raw;
        int unsigned   bandgap;
        int unsigned   quotient;
        t_vdd_estimate r;
        mark         = trim_lo_a[7:4];
        r.error      = 1'b0;
        r.trim_valid = 1'b1;
        bandgap      = 0;
        if (mark == MARK_A || mark == MARK_A_OFS) begin
            raw     = 32'({trim_hi_a, trim_lo_a[3:0]});
            bandgap = raw * 3 / 4;
            if (mark == MARK_A_OFS) begin
                // The offset layout saturates at zero rather than wrapping.
                if (bandgap < 32'(MARK_A_OFS_MV)) begin
                    r.error = 1'b1;
                    bandgap = 0;
                end else begin
                    bandgap = bandgap - 32'(MARK_A_OFS_MV);
                end
            end
        end else if (mark == MARK_B) begin
            raw     = 32'({trim_hi_b, trim_lo_b[3:0]});
            bandgap = raw * 3 / 4;
        end else begin
            r.trim_valid = 1'b0;
        end
        if (divisor == 0) begin
            r.vdd_mv = VDD_SAT;
            r.error  = 1'b1;
        end else begin
            quotient = (32'd4096 * bandgap) / divisor;
            if (quotient > 32'hFFFF) begin
                r.vdd_mv = VDD_SAT;
                r.error  = 1'b1;
            end else begin
                r.vdd_mv = quotient[VDD_W-1:0];
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_vdd_estimate want;
        int            pushed;
        int            popped;
        int unsigned   kept;
        if (!i_rst_n) begin
            trim_hi_a    = '0;
            trim_lo_a    = '0;
            trim_hi_b    = '0;
            trim_lo_b    = '0;
            series_count = 0;
            series_sum   = 0;
            expected_vdd_q.delete();
            o_pending   <= 0;
        end else begin
            pushed = 0;
            popped = 0;
            if (i_strobe) begin
                if (expected_vdd_q.size() == 0) begin
                    $display("%0t ns: result with none expected, actual vdd_mv %0d",
                             $time, i_vdd_mv, " error %0b trim_valid %0b",
                             i_error, i_trim_valid);
                    mismatch_count++;
                end else begin
                    want   = expected_vdd_q.pop_front();
                    popped = 1;
                    if (i_vdd_mv !== want.vdd_mv) begin
                        $display("%0t ns: vdd_mv mismatch, expected %0d, actual %0d",
                                 $time, want.vdd_mv, i_vdd_mv);
                        mismatch_count++;
                    end
                    if (i_error !== want.error) begin
                        $display("%0t ns: error mismatch, expected %0b, actual %0b",
                                 $time, want.error, i_error);
                        mismatch_count++;
                    end
                    if (i_trim_valid !== want.trim_valid) begin
                        $display("%0t ns: trim_valid mismatch, expected %0b, actual %0b",
                                 $time, want.trim_valid, i_trim_valid);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TRIM_HI_A: trim_hi_a = i_cfg_data;
                    CFG_TRIM_LO_A: trim_lo_a = i_cfg_data;
                    CFG_TRIM_HI_B: trim_hi_b = i_cfg_data;
                    CFG_TRIM_LO_B: trim_lo_b = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                if (i_opcode == OP_DIRECT) begin
                    expected_vdd_q.push_back(predict_vdd(32'(i_sample)));
                    pushed = 1;
                end else begin
                    if (series_count >= SAMPLES_DISCARDED)
                        series_sum += 32'(i_sample);
                    series_count++;
                    if (series_count >= SAMPLES_PER_MEASURE) begin
                        kept = (SAMPLES_PER_MEASURE > SAMPLES_DISCARDED) ?
                               SAMPLES_PER_MEASURE - SAMPLES_DISCARDED : 0;
                        expected_vdd_q.push_back(predict_vdd(kept == 0 ? 0 : series_sum / kept));
                        pushed       = 1;
                        series_count = 0;
                        series_sum   = 0;
                    end
                end
            end
            o_pending <= o_pending + pushed - popped;
        end
    end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Top of the bandgap VDD estimator bench: clock, reset, trim writes and sample beats.
// Depends on bgv_pkg, bandgap_vdd_estimator_top and bgv_vdd_checker.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bgv_pkg::*;

    localparam int SPM             = 5;
    localparam int SKIPPED         = 2;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 185;
    localparam int SETTLE_CYCLES   = 64;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic                 i_opcode;
    logic [SMP_W-1:0]     i_sample;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 o_strobe;
    logic [VDD_W-1:0]     o_vdd_mv;
    logic                 o_error;
    logic                 o_trim_valid;
    int                   pending;
    int                   fail_count;
    bit                   idle_on;

    always #5 i_clk = ~i_clk;

    bandgap_vdd_estimator_top #(
        .SAMPLES_PER_MEASURE(SPM),
        .SAMPLES_DISCARDED  (SKIPPED)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_opcode    (i_opcode),
        .i_sample    (i_sample),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_vdd_mv    (o_vdd_mv),
        .o_error     (o_error),
        .o_trim_valid(o_trim_valid)
    );

    bgv_vdd_checker #(
        .SAMPLES_PER_MEASURE(SPM),
        .SAMPLES_DISCARDED  (SKIPPED)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_busy      (o_busy),
        .i_opcode    (i_opcode),
        .i_sample    (i_sample),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_strobe    (o_strobe),
        .i_vdd_mv    (o_vdd_mv),
        .i_error     (o_error),
        .i_trim_valid(o_trim_valid),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    // Issues one beat, after random idle cycles when idling is on, and returns at the
    // edge that accepts it.
    task automatic send_item(input logic op, input logic [SMP_W-1:0] smp);
        while (idle_on && $urandom_range(0, 99) < 36) begin
            i_start  <= 1'b0;
            i_opcode <= 1'($urandom_range(0, 1));
            i_sample <= SMP_W'($urandom_range(0, 4095));
            @(posedge i_clk);
        end
        i_start  <= 1'b1;
        i_opcode <= op;
        i_sample <= smp;
        do @(posedge i_clk); while (o_busy);
    endtask

    // Holds off until every predicted result has come and the block has settled.
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || o_busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_trims(input logic [CFG_W-1:0] hi_a, input logic [CFG_W-1:0] lo_a,
                             input logic [CFG_W-1:0] hi_b, input logic [CFG_W-1:0] lo_b);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TRIM_HI_A;
        i_cfg_data  <= hi_a;
        @(posedge i_clk);
        i_cfg_index <= CFG_TRIM_LO_A;
        i_cfg_data  <= lo_a;
        @(posedge i_clk);
        i_cfg_index <= CFG_TRIM_HI_B;
        i_cfg_data  <= hi_b;
        @(posedge i_clk);
        i_cfg_index <= CFG_TRIM_LO_B;
        i_cfg_data  <= lo_b;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Leans towards zero, full scale and tiny divisors, which hit saturation.
    function automatic logic [SMP_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return SMP_W'($urandom_range(1, 31));
            default: return SMP_W'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_trim_high();
        case ($urandom_range(0, 4))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return CFG_W'($urandom_range(0, 4));
            default: return CFG_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_trims();
        logic [CFG_W-1:0] lo_a;
        logic [3:0]       mark;
        case ($urandom_range(0, 4))
            0: mark = MARK_A;
            1: mark = MARK_A_OFS;
            2: mark = MARK_B;
            3: begin
                do mark = 4'($urandom_range(0, 15));
                while (mark == MARK_A || mark == MARK_A_OFS || mark == MARK_B);
            end
            default: mark = 4'($urandom_range(0, 15));
        endcase
        lo_a[7:4] = mark;
        lo_a[3:0] = 4'($urandom_range(0, 15));
        set_trims(pick_trim_high(), lo_a, pick_trim_high(), CFG_W'($urandom_range(0, 255)));
    endtask

    initial begin
        int sent;
        int kind;
        int burst;
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_opcode    <= OP_SERIES;
        i_sample    <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_TRIM_HI_A;
        i_cfg_data  <= '0;
        idle_on      = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n     <= 1'b1;

        // Trims straight out of reset give a zero bandgap.
        send_item(OP_DIRECT, 12'd0);
        send_item(OP_DIRECT, 12'd4095);
        drain();

        // Largest layout A bandgap: overflow, full scale, zero average and a normal average.
        set_trims(8'hFF, 8'h0F, 8'h00, 8'h00);
        send_item(OP_DIRECT, 12'd1);
        send_item(OP_DIRECT, 12'd4095);
        send_item(OP_SERIES, 12'd0);
        send_item(OP_SERIES, 12'd0);
        send_item(OP_SERIES, 12'd4095);
        send_item(OP_SERIES, 12'd4095);
        send_item(OP_SERIES, 12'd4095);
        send_item(OP_SERIES, 12'd4095);
        send_item(OP_SERIES, 12'd4095);
        send_item(OP_SERIES, 12'd0);
        send_item(OP_SERIES, 12'd0);
        send_item(OP_SERIES, 12'd0);
        drain();

        // Offset layout with a bandgap below the offset.
        set_trims(8'h01, 8'h8F, 8'h00, 8'h00);
        send_item(OP_DIRECT, 12'd100);
        drain();

        // Offset layout above the offset, with a direct beat in the middle of a series.
        set_trims(8'h80, 8'h80, 8'h00, 8'h00);
        send_item(OP_SERIES, 12'd10);
        send_item(OP_SERIES, 12'd20);
        send_item(OP_DIRECT, 12'd600);
        send_item(OP_SERIES, 12'd3000);
        send_item(OP_SERIES, 12'd3000);
        send_item(OP_SERIES, 12'd3001);
        drain();

        // Layout B; the upper nibble of its low byte must be ignored.
        set_trims(8'h00, 8'h9F, 8'hFF, 8'hFF);
        send_item(OP_DIRECT, 12'd2048);
        drain();

        // Unknown layout marks.
        set_trims(8'hFF, 8'h5F, 8'hFF, 8'h0F);
        send_item(OP_DIRECT, 12'd0);
        send_item(OP_DIRECT, 12'd7);
        drain();
        set_trims(8'hFF, 8'hF0, 8'hFF, 8'hF0);
        send_item(OP_DIRECT, 12'd4095);
        drain();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            random_trims();
            // One phase runs back to back with no gaps at all.
            idle_on = (phase != 4);
            sent    = 0;
            while (sent < ITEMS_PER_PHASE) begin
                kind = $urandom_range(0, 99);
                if (kind < 70) begin
                    for (int k = 0; k < SPM; k++) begin
                        if ($urandom_range(0, 19) == 0) begin
                            send_item(OP_DIRECT, pick_sample());
                            sent++;
                        end
                        send_item(OP_SERIES, pick_sample());
                        sent++;
                    end
                end else if (kind < 88) begin
                    send_item(OP_DIRECT, pick_sample());
                    sent++;
                end else begin
                    // A broken run of series beats, which shifts the measurement boundary.
                    burst = $urandom_range(1, SPM - 1);
                    for (int k = 0; k < burst; k++) begin
                        send_item(OP_SERIES, pick_sample());
                        sent++;
                    end
                end
                if (idle_on && $urandom_range(0, 39) == 0)
                    drain();
            end
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/bgv_pkg.sv
rtl/core/bgv_trim.sv
rtl/core/bgv_divider.sv
rtl/core/bandgap_vdd_estimator_top.sv
rtl/core/bgv_checker.sv
bench/bgv_vdd_checker.sv
bench/testbench.sv
